// ===== hw/rtl/agb_pkg.sv =====
// Shared types, constants and register codes for the agent integrate-and-bin block.
// No dependencies; every other file of the block imports this package.
package agb_pkg;

  // Grid limits and derived widths.
  localparam int unsigned MaxCellsPerAxis = 16;
  localparam int unsigned CellW = $clog2(MaxCellsPerAxis);
  localparam int unsigned CountW = $clog2(MaxCellsPerAxis + 1);
  localparam int unsigned N2W = 2 * CountW;
  localparam int unsigned YTermW = CellW + CountW;
  localparam int unsigned ZTermW = CellW + N2W;
  localparam int unsigned CellNumW = 12;
  localparam int unsigned SumW = (ZTermW + 2 > CellNumW) ? ZTermW + 2 : CellNumW;
  localparam int unsigned LenShW = 31 + CellW;

  // Iteration counts of the square root and divider pipelines.
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps = 31;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_FIELD_EXTENT   = 3'd0,
    CFG_CELL_EDGE      = 3'd1,
    CFG_HALO_BAND      = 3'd2,
    CFG_CELLS_PER_AXIS = 3'd3,
    CFG_SPEED_CEILING  = 3'd4,
    CFG_SPEED_FLOOR    = 3'd5
  } agb_cfg_idx_e;

  // Working configuration, derived from the raw registers.
  typedef struct packed {
    logic [30:0]          fe;
    logic [30:0]          cell_len;
    logic [30:0]          halo;
    logic [CountW-1:0]    n;
    logic [CellW-1:0]     n_m1;
    logic [N2W-1:0]       n2;
    logic [LenShW-1:0]    top_base;
    logic [32:0]          len_m_halo;
    logic [30:0]          spd_max;
    logic [30:0]          spd_min;
    logic [61:0]          spd_max_sq;
    logic [61:0]          spd_min_sq;
  } agb_cfg_t;

  // Position and velocity of one agent.
  typedef struct packed {
    logic [2:0][30:0] pos;
    logic [2:0][31:0] vel;
  } agb_vec_t;

  // Result of the velocity unit.
  typedef struct packed {
    agb_vec_t    vec;
    logic [63:0] sq_sum;
    logic        rescale;
    logic [30:0] limit;
  } agb_vres_t;

  // One stage of the square root pipeline.
  typedef struct packed {
    agb_vec_t    vec;
    logic        rescale;
    logic [30:0] limit;
    logic [63:0] rad;
    logic [31:0] root;
    logic [34:0] rem;
  } agb_sq_t;

  // Square root pipeline result.
  typedef struct packed {
    agb_vec_t    vec;
    logic        rescale;
    logic [30:0] limit;
    logic [31:0] norm;
  } agb_sqres_t;

  // One stage of the divider pipeline.
  typedef struct packed {
    agb_vec_t         vec;
    logic             rescale;
    logic [2:0]       neg;
    logic [31:0]      norm;
    logic [2:0][62:0] rem;
    logic [2:0][30:0] quo;
  } agb_dv_t;

  // One stage of the cell search.
  typedef struct packed {
    agb_vec_t               vec;
    logic [2:0][30:0]       rem;
    logic [2:0][CellW-1:0]  c;
  } agb_srch_t;

  // Home and neighbour cell of each axis.
  typedef struct packed {
    agb_vec_t               vec;
    logic [2:0]             mask;
    logic [2:0][CellW-1:0]  home;
    logic [2:0][CellW-1:0]  nb;
  } agb_halo_t;

  // Item handed to the result sequencer: index 0 is home, 1 is neighbour.
  typedef struct packed {
    agb_vec_t               vec;
    logic [2:0]             mask;
    logic [1:0][CellW-1:0]  xc;
    logic [1:0][YTermW-1:0] yt;
    logic [1:0][ZTermW-1:0] zt;
  } agb_cells_t;

endpackage

// ===== hw/rtl/agb_vel_unit.sv =====
// Velocity unit: saturating add of the change, squared speed and limit decision.
// Depends on agb_pkg.
module agb_vel_unit import agb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             vld_i,
  input  agb_vec_t         vec_i,
  input  logic [2:0][31:0] delta_i,
  input  agb_cfg_t         cfg_i,
  output logic             vld_o,
  output agb_vres_t        res_o
);

  logic [2:0][32:0] sum1;
  logic [2:0][31:0] sat1;
  agb_vec_t         vec1_q, vec2_q, vec3_q;
  logic [2:0][31:0] mag2;
  logic [2:0][63:0] sq2_d, sq2_q;
  logic [63:0]      s3_q;
  logic             vld1_q, vld2_q, vld3_q, vld4_q;
  agb_vres_t        res4_q;

  // Saturating velocity sum.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum1[a] = {vec_i.vel[a][31], vec_i.vel[a]} + {delta_i[a][31], delta_i[a]};
      if (sum1[a][32] != sum1[a][31]) begin
        sat1[a] = sum1[a][32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
      end else begin
        sat1[a] = sum1[a][31:0];
      end
    end
  end

  // Magnitudes and their squares.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag2[a] = vec1_q.vel[a][31] ? (~vec1_q.vel[a] + 32'd1) : vec1_q.vel[a];
      sq2_d[a] = mag2[a] * mag2[a];
    end
  end

  // Valid bits of the four stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else if (adv_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  // Stage payloads; the last stage picks the limit to scale towards.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      vec1_q.pos <= vec_i.pos;
      vec1_q.vel <= sat1;
      vec2_q <= vec1_q;
      sq2_q <= sq2_d;
      vec3_q <= vec2_q;
      s3_q <= sq2_q[0] + sq2_q[1] + sq2_q[2];
      res4_q.vec <= vec3_q;
      res4_q.sq_sum <= s3_q;
      if (s3_q > {2'b00, cfg_i.spd_max_sq}) begin
        res4_q.rescale <= 1'b1;
        res4_q.limit <= cfg_i.spd_max;
      end else begin
        res4_q.rescale <= (s3_q != 64'd0) && (s3_q < {2'b00, cfg_i.spd_min_sq});
        res4_q.limit <= cfg_i.spd_min;
      end
    end
  end

  assign vld_o = vld4_q;
  assign res_o = res4_q;

endmodule

// ===== hw/rtl/agb_sqrt_pipe.sv =====
// Integer square root of the squared speed, one result bit per pipeline stage.
// Depends on agb_pkg.
module agb_sqrt_pipe import agb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic       vld_i,
  input  agb_vres_t  res_i,
  output logic       vld_o,
  output agb_sqres_t res_o
);

  agb_sq_t st_first;
  agb_sq_t st_q [1:SqrtSteps];
  logic    vld_q [1:SqrtSteps];

  // The root and remainder start at zero.
  always_comb begin
    st_first.vec = res_i.vec;
    st_first.rescale = res_i.rescale;
    st_first.limit = res_i.limit;
    st_first.rad = res_i.sq_sum;
    st_first.root = 32'd0;
    st_first.rem = 35'd0;
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    agb_sq_t     cur, nxt;
    logic        cur_vld;
    logic [34:0] rem_sh, trial;
    logic        ge;

    if (k == 0) begin : g_head
      assign cur = st_first;
      assign cur_vld = vld_i;
    end else begin : g_body
      assign cur = st_q[k];
      assign cur_vld = vld_q[k];
    end

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
      rem_sh = {cur.rem[32:0], cur.rad[63:62]};
      trial = {1'b0, cur.root, 2'b01};
      ge = rem_sh >= trial;
      nxt = cur;
      nxt.rad = {cur.rad[61:0], 2'b00};
      nxt.root = {cur.root[30:0], ge};
      nxt.rem = ge ? rem_sh - trial : rem_sh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        st_q[k+1] <= nxt;
      end
    end
  end

  assign vld_o = vld_q[SqrtSteps];
  assign res_o.vec = st_q[SqrtSteps].vec;
  assign res_o.rescale = st_q[SqrtSteps].rescale;
  assign res_o.limit = st_q[SqrtSteps].limit;
  assign res_o.norm = st_q[SqrtSteps].root;

endmodule

// ===== hw/rtl/agb_scale_pipe.sv =====
// Speed rescaling: magnitude times limit, then a restoring divide by the norm.
// Depends on agb_pkg.
module agb_scale_pipe import agb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic       vld_i,
  input  agb_sqres_t res_i,
  output logic       vld_o,
  output agb_vec_t   vec_o
);

  agb_dv_t          dv_first_d;
  logic [2:0][31:0] mag;
  agb_dv_t          dv_q [0:DivSteps];
  logic             vld_q [0:DivSteps];
  agb_dv_t          last;
  logic             out_vld_q;
  agb_vec_t         out_q;

  // Product stage: magnitude times limit, sign kept apart.
  always_comb begin
    dv_first_d.vec = res_i.vec;
    dv_first_d.rescale = res_i.rescale;
    dv_first_d.norm = res_i.norm;
    for (int a = 0; a < 3; a++) begin
      dv_first_d.neg[a] = res_i.vec.vel[a][31];
      mag[a] = res_i.vec.vel[a][31] ? (~res_i.vec.vel[a] + 32'd1) : res_i.vec.vel[a];
      dv_first_d.rem[a] = mag[a] * res_i.limit;
      dv_first_d.quo[a] = 31'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dv_q[0] <= dv_first_d;
    end
  end

  // One quotient bit per stage for each axis.
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    localparam int unsigned Sh = DivSteps - 1 - k;
    agb_dv_t     nxt;
    logic [62:0] dsh;
    logic [2:0]  ge;

    always_comb begin
      nxt = dv_q[k];
      dsh = {31'd0, dv_q[k].norm} << Sh;
      for (int a = 0; a < 3; a++) begin
        ge[a] = dv_q[k].rem[a] >= dsh;
        nxt.rem[a] = ge[a] ? dv_q[k].rem[a] - dsh : dv_q[k].rem[a];
        nxt.quo[a] = {dv_q[k].quo[a][29:0], ge[a]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dv_q[k+1] <= nxt;
      end
    end
  end

  assign last = dv_q[DivSteps];

  // Restore the sign, or pass the velocity when no rescaling is due.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv_i) begin
      out_vld_q <= vld_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q.pos <= last.vec.pos;
      for (int a = 0; a < 3; a++) begin
        if (!last.rescale) begin
          out_q.vel[a] <= last.vec.vel[a];
        end else if (last.neg[a]) begin
          out_q.vel[a] <= ~{1'b0, last.quo[a]} + 32'd1;
        end else begin
          out_q.vel[a] <= {1'b0, last.quo[a]};
        end
      end
    end
  end

  assign vld_o = out_vld_q;
  assign vec_o = out_q;

endmodule

// ===== hw/rtl/agb_bin_pipe.sv =====
// Position update with wrap, then grid binning and halo neighbour selection.
// Depends on agb_pkg.
module agb_bin_pipe import agb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic       vld_i,
  input  agb_vec_t   vec_i,
  input  agb_cfg_t   cfg_i,
  output logic       vld_o,
  output agb_cells_t cells_o
);

  logic [33:0]      fe34;
  logic [2:0][33:0] sum1_q, wrap2_q;
  logic [2:0][33:0] wrap2_d;
  logic [2:0][30:0] pos3_d;
  logic [31:0]      vel1_q [3], vel2_q [3];
  logic             vld1_q, vld2_q, vld3_q;
  agb_srch_t        srch3_q;
  agb_srch_t        srch_q [1:CellW];
  logic             svld_q [1:CellW];
  agb_srch_t        clamp_d, clamp_q;
  logic             vld_c_q;
  agb_halo_t        halo_d, halo_q;
  logic             vld_h_q;
  agb_cells_t       cells_d, cells_q;
  logic             vld_o_q;
  logic [CellW+CountW-1:0] yprod [2];
  logic [CellW+N2W-1:0]    zprod [2];

  assign fe34 = {3'b000, cfg_i.fe};

  // Wrap once, then clamp into the field.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if ($signed(sum1_q[a]) < 0) begin
        wrap2_d[a] = sum1_q[a] + fe34;
      end else if ($signed(sum1_q[a]) > $signed(fe34)) begin
        wrap2_d[a] = sum1_q[a] - fe34;
      end else begin
        wrap2_d[a] = sum1_q[a];
      end
      if ($signed(wrap2_q[a]) < 0) begin
        pos3_d[a] = 31'd0;
      end else if ($signed(wrap2_q[a]) > $signed(fe34)) begin
        pos3_d[a] = cfg_i.fe;
      end else begin
        pos3_d[a] = wrap2_q[a][30:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (adv_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  // Add velocity, wrap, clamp; the search starts with the full position.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int a = 0; a < 3; a++) begin
        sum1_q[a] <= {3'b000, vec_i.pos[a]} + {{2{vec_i.vel[a][31]}}, vec_i.vel[a]};
        vel1_q[a] <= vec_i.vel[a];
        vel2_q[a] <= vel1_q[a];
        srch3_q.vec.vel[a] <= vel2_q[a];
      end
      wrap2_q <= wrap2_d;
      srch3_q.vec.pos <= pos3_d;
      srch3_q.rem <= pos3_d;
      srch3_q.c <= '0;
    end
  end

  // Cell coordinate, one bit per stage, saturating at the top code.
  for (genvar k = 0; k < CellW; k++) begin : g_srch
    localparam int unsigned Sh = CellW - 1 - k;
    agb_srch_t          cur, nxt;
    logic               cur_vld;
    logic [LenShW-1:0]  thr;

    if (k == 0) begin : g_head
      assign cur = srch3_q;
      assign cur_vld = vld3_q;
    end else begin : g_body
      assign cur = srch_q[k];
      assign cur_vld = svld_q[k];
    end

    always_comb begin
      nxt = cur;
      thr = LenShW'(cfg_i.cell_len) << Sh;
      for (int a = 0; a < 3; a++) begin
        if (LenShW'(cur.rem[a]) >= thr) begin
          nxt.rem[a] = cur.rem[a] - thr[30:0];
          nxt.c[a][Sh] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        svld_q[k+1] <= 1'b0;
      end else if (adv_i) begin
        svld_q[k+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        srch_q[k+1] <= nxt;
      end
    end
  end

  // Clamp to the top cell of the configured grid.
  always_comb begin
    clamp_d = srch_q[CellW];
    for (int a = 0; a < 3; a++) begin
      if (srch_q[CellW].c[a] > cfg_i.n_m1) begin
        clamp_d.c[a] = cfg_i.n_m1;
        clamp_d.rem[a] = srch_q[CellW].vec.pos[a] - cfg_i.top_base[30:0];
      end
    end
  end

  // Halo test against both cell faces, with periodic neighbours.
  always_comb begin
    halo_d.vec = clamp_q.vec;
    for (int a = 0; a < 3; a++) begin
      halo_d.home[a] = clamp_q.c[a];
      if (clamp_q.rem[a] < cfg_i.halo) begin
        halo_d.mask[2-a] = 1'b1;
        halo_d.nb[a] = (clamp_q.c[a] == '0) ? cfg_i.n_m1 : clamp_q.c[a] - 1'b1;
      end else begin
        halo_d.mask[2-a] = $signed({2'b00, clamp_q.rem[a]}) >= $signed(cfg_i.len_m_halo);
        halo_d.nb[a] = (clamp_q.c[a] == cfg_i.n_m1) ? '0 : clamp_q.c[a] + 1'b1;
      end
    end
  end

  // Weighted terms of the linear cell number.
  always_comb begin
    cells_d.vec = halo_q.vec;
    cells_d.mask = halo_q.mask;
    cells_d.xc[0] = halo_q.home[0];
    cells_d.xc[1] = halo_q.nb[0];
    yprod[0] = halo_q.home[1] * cfg_i.n;
    yprod[1] = halo_q.nb[1] * cfg_i.n;
    zprod[0] = halo_q.home[2] * cfg_i.n2;
    zprod[1] = halo_q.nb[2] * cfg_i.n2;
    for (int i = 0; i < 2; i++) begin
      cells_d.yt[i] = yprod[i][YTermW-1:0];
      cells_d.zt[i] = zprod[i][ZTermW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
      vld_h_q <= 1'b0;
      vld_o_q <= 1'b0;
    end else if (adv_i) begin
      vld_c_q <= svld_q[CellW];
      vld_h_q <= vld_c_q;
      vld_o_q <= vld_h_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      clamp_q <= clamp_d;
      halo_q <= halo_d;
      cells_q <= cells_d;
    end
  end

  assign vld_o = vld_o_q;
  assign cells_o = cells_q;

endmodule

// ===== hw/rtl/agb_cell_emit.sv =====
// Result sequencer: one cell result per cycle, home first, then the halo cells.
// Depends on agb_pkg.
module agb_cell_emit import agb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  agb_cells_t          cells_i,
  output logic                adv_o,
  output logic                strobe_o,
  output agb_vec_t            vec_o,
  output logic [CellNumW-1:0] cell_o,
  output logic                last_o
);

  logic       act_q;
  logic [2:0] idx_q, idx_nxt;
  agb_cells_t it_q;
  logic       at_last;
  logic [SumW-1:0] cell_sum;

  // Next subset of the neighbour mask, x slowest and z fastest.
  assign at_last = (idx_q == it_q.mask);
  assign idx_nxt = ((idx_q | ~it_q.mask) + 3'd1) & it_q.mask;
  assign adv_o = !act_q || at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      idx_q <= 3'd0;
    end else if (adv_o) begin
      act_q <= vld_i;
      idx_q <= 3'd0;
    end else begin
      idx_q <= idx_nxt;
    end
  end

  // Take a new item when idle or when the current one shows its last result.
  always_ff @(posedge clk_i) begin
    if (adv_o && vld_i) begin
      it_q <= cells_i;
    end
  end

  assign cell_sum = SumW'(it_q.xc[idx_q[2]]) + SumW'(it_q.yt[idx_q[1]])
                  + SumW'(it_q.zt[idx_q[0]]);

  assign strobe_o = act_q;
  assign vec_o = it_q.vec;
  assign cell_o = cell_sum[CellNumW-1:0];
  assign last_o = at_last;

endmodule

// ===== hw/rtl/agent_integrate_and_grid_bin.sv =====
// Top level of the agent integrate-and-bin block: configuration registers and pipeline.
// Depends on agb_pkg, agb_vel_unit, agb_sqrt_pipe, agb_scale_pipe, agb_bin_pipe
// and agb_cell_emit.
//
// Use: an item (one agent's position, velocity and velocity change) is taken at a
// rising edge with start high and busy low. Each item yields one to eight cell
// results, home cell first, each shown for exactly one cycle with out_strobe_o high;
// final_cell_o marks the last result of the item. Every result repeats the new
// position and velocity.
// Path: with no stall, an item passes 4 velocity stages, 32 square root stages,
// 33 product and divide stages, 10 binning stages and the result register before
// its home cell shows on the result ports.
// Throughput: the pipeline takes one item per cycle while the sequencer is free; the
// sequencer emits one result per cycle, and an item with several results holds every
// stage, with busy high, until its last result shows.
// Configuration: registers are written through cfg_valid_i/cfg_ready_o, always
// ready; the user must write them only while no item is in flight, which the block
// does not enforce. Reset clears all valid bits and loads the register defaults.
// The receiver cannot stall the results.
module agent_integrate_and_grid_bin import agb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [30:0]         pos_x_i,
  input  logic [30:0]         pos_y_i,
  input  logic [30:0]         pos_z_i,
  input  logic signed [31:0]  vel_x_i,
  input  logic signed [31:0]  vel_y_i,
  input  logic signed [31:0]  vel_z_i,
  input  logic signed [31:0]  delta_x_i,
  input  logic signed [31:0]  delta_y_i,
  input  logic signed [31:0]  delta_z_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output logic                out_strobe_o,
  output logic [30:0]         new_pos_x_o,
  output logic [30:0]         new_pos_y_o,
  output logic [30:0]         new_pos_z_o,
  output logic signed [31:0]  new_vel_x_o,
  output logic signed [31:0]  new_vel_y_o,
  output logic signed [31:0]  new_vel_z_o,
  output logic [CellNumW-1:0] cell_number_o,
  output logic                final_cell_o
);

  logic [30:0] fe_q, len_q, halo_q, spd_max_q, spd_min_q;
  logic [4:0]  cpa_q;
  logic [30:0] len_eff;
  logic [CountW-1:0] n_eff;
  logic [CellW-1:0]  n_m1;
  agb_cfg_t    cfg_d, cfg_q;
  logic        adv, accept;
  agb_vec_t    in_vec;
  logic [2:0][31:0] in_delta;
  logic        vu_vld, sq_vld, sc_vld, bn_vld;
  agb_vres_t   vu_res;
  agb_sqres_t  sq_res;
  agb_vec_t    sc_vec, out_vec;
  agb_cells_t  bn_cells;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_q <= 31'd6553600;
      len_q <= 31'd409600;
      halo_q <= 31'd163840;
      cpa_q <= 5'd16;
      spd_max_q <= 31'd131072;
      spd_min_q <= 31'd32768;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (agb_cfg_idx_e'(cfg_index_i))
        CFG_FIELD_EXTENT:   fe_q <= cfg_data_i[30:0];
        CFG_CELL_EDGE:      len_q <= cfg_data_i[30:0];
        CFG_HALO_BAND:      halo_q <= cfg_data_i[30:0];
        CFG_CELLS_PER_AXIS: cpa_q <= cfg_data_i[4:0];
        CFG_SPEED_CEILING:  spd_max_q <= cfg_data_i[30:0];
        CFG_SPEED_FLOOR:    spd_min_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Working configuration: clamped grid size, products and differences.
  always_comb begin
    len_eff = (len_q == 31'd0) ? 31'd1 : len_q;
    if (cpa_q < 5'd3) begin
      n_eff = CountW'(3);
    end else if (32'(cpa_q) > MaxCellsPerAxis) begin
      n_eff = CountW'(MaxCellsPerAxis);
    end else begin
      n_eff = CountW'(cpa_q);
    end
    n_m1 = CellW'(n_eff - 1'b1);
    cfg_d.fe = fe_q;
    cfg_d.cell_len = len_eff;
    cfg_d.halo = halo_q;
    cfg_d.n = n_eff;
    cfg_d.n_m1 = n_m1;
    cfg_d.n2 = n_eff * n_eff;
    cfg_d.top_base = n_m1 * len_eff;
    cfg_d.len_m_halo = {2'b00, len_eff} - {2'b00, halo_q};
    cfg_d.spd_max = spd_max_q;
    cfg_d.spd_min = spd_min_q;
    cfg_d.spd_max_sq = spd_max_q * spd_max_q;
    cfg_d.spd_min_sq = spd_min_q * spd_min_q;
  end

  always_ff @(posedge clk_i) begin
    cfg_q <= cfg_d;
  end

  // Intake: all stages move together whenever the sequencer can take an item.
  assign busy = !adv;
  assign accept = start && !busy;

  assign in_vec.pos = {pos_z_i, pos_y_i, pos_x_i};
  assign in_vec.vel = {vel_z_i, vel_y_i, vel_x_i};
  assign in_delta = {delta_z_i, delta_y_i, delta_x_i};

  agb_vel_unit u_vel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .vld_i   (accept),
    .vec_i   (in_vec),
    .delta_i (in_delta),
    .cfg_i   (cfg_q),
    .vld_o   (vu_vld),
    .res_o   (vu_res)
  );

  agb_sqrt_pipe u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (vu_vld),
    .res_i  (vu_res),
    .vld_o  (sq_vld),
    .res_o  (sq_res)
  );

  agb_scale_pipe u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (sq_vld),
    .res_i  (sq_res),
    .vld_o  (sc_vld),
    .vec_o  (sc_vec)
  );

  agb_bin_pipe u_bin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .vld_i   (sc_vld),
    .vec_i   (sc_vec),
    .cfg_i   (cfg_q),
    .vld_o   (bn_vld),
    .cells_o (bn_cells)
  );

  agb_cell_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (bn_vld),
    .cells_i  (bn_cells),
    .adv_o    (adv),
    .strobe_o (out_strobe_o),
    .vec_o    (out_vec),
    .cell_o   (cell_number_o),
    .last_o   (final_cell_o)
  );

  assign new_pos_x_o = out_vec.pos[0];
  assign new_pos_y_o = out_vec.pos[1];
  assign new_pos_z_o = out_vec.pos[2];
  assign new_vel_x_o = out_vec.vel[0];
  assign new_vel_y_o = out_vec.vel[1];
  assign new_vel_z_o = out_vec.vel[2];

endmodule

// ===== test/agb_result_checker.sv =====
// Result checker for the agent integrate-and-bin block: predicts the cell results of
// each accepted item and compares them with the block's output strobes.
// Depends on agb_pkg for the register indexes, the grid limit and the cell number width.
`timescale 1ns / 100ps

module agb_result_checker import agb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                busy,
  input  logic [30:0]         pos_x_i,
  input  logic [30:0]         pos_y_i,
  input  logic [30:0]         pos_z_i,
  input  logic signed [31:0]  vel_x_i,
  input  logic signed [31:0]  vel_y_i,
  input  logic signed [31:0]  vel_z_i,
  input  logic signed [31:0]  delta_x_i,
  input  logic signed [31:0]  delta_y_i,
  input  logic signed [31:0]  delta_z_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                out_strobe_i,
  input  logic [30:0]         new_pos_x_i,
  input  logic [30:0]         new_pos_y_i,
  input  logic [30:0]         new_pos_z_i,
  input  logic signed [31:0]  new_vel_x_i,
  input  logic signed [31:0]  new_vel_y_i,
  input  logic signed [31:0]  new_vel_z_i,
  input  logic [CellNumW-1:0] cell_number_i,
  input  logic                final_cell_i,
  output int                  errors_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [2:0][30:0]    pos;
    logic [2:0][31:0]    vel;
    logic [CellNumW-1:0] cell_num;
    logic                last;
  } cell_result_t;

  cell_result_t cell_queue[$];

  // Shadow copy of the configuration registers.
  logic [30:0] field_ext, cell_len, halo_len, spd_max, spd_min;
  logic [4:0]  grid_n;

  assign pending_o = cell_queue.size();

  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Integrates one agent and queues its home and halo cells.
  function automatic void predict_cells(input logic [2:0][30:0] p_in,
                                        input logic signed [2:0][31:0] v_in,
                                        input logic signed [2:0][31:0] d_in);
    longint v[3];
    longint q, c, r, fe, edge_len, halo, t;
    longint unsigned s, mag, lim, norm, n;
    longint unsigned home[3], nb[3];
    bit has_nb[3];
    bit do_scale;
    cell_result_t res;
    fe = longint'(field_ext);
    edge_len = (cell_len == 0) ? 1 : longint'(cell_len);
    halo = longint'(halo_len);
    n = grid_n;
    if (n < 3) n = 3;
    if (n > MaxCellsPerAxis) n = MaxCellsPerAxis;
    s = 0;
    // Saturating velocity sum and squared speed.
    for (int a = 0; a < 3; a++) begin
      t = longint'($signed(v_in[a])) + longint'($signed(d_in[a]));
      if (t > 64'sh7FFFFFFF) t = 64'sh7FFFFFFF;
      if (t < -64'sh80000000) t = -64'sh80000000;
      v[a] = t;
      mag = (t < 0) ? -t : t;
      s += mag * mag;
    end
    // Speed limiting into the floor and ceiling band.
    do_scale = 0;
    lim = 0;
    if (s != 0) begin
      if (s > longint'(spd_max) * longint'(spd_max)) begin
        lim = spd_max;
        do_scale = 1;
      end else if (s < longint'(spd_min) * longint'(spd_min)) begin
        lim = spd_min;
        do_scale = 1;
      end
    end
    if (do_scale) begin
      norm = root_floor(s);
      for (int a = 0; a < 3; a++) begin
        mag = (v[a] < 0) ? -v[a] : v[a];
        mag = mag * lim / norm;
        v[a] = (v[a] < 0) ? -longint'(mag) : longint'(mag);
      end
    end
    // Advance, wrap once, clamp and bin each axis.
    for (int a = 0; a < 3; a++) begin
      q = longint'(p_in[a]) + v[a];
      if (q < 0) q = fe + q;
      else if (q > fe) q = q - fe;
      if (q < 0) q = 0;
      if (q > fe) q = fe;
      res.pos[a] = q[30:0];
      res.vel[a] = v[a][31:0];
      c = q / edge_len;
      if (c > longint'(n) - 1) c = longint'(n) - 1;
      r = q - c * edge_len;
      home[a] = c;
      has_nb[a] = 1;
      if (r < halo) nb[a] = (c + n - 1) % n;
      else if (r >= edge_len - halo) nb[a] = (c + 1) % n;
      else has_nb[a] = 0;
    end
    // Home first, then halo cells with x slowest and z fastest.
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 2; k++) begin
          if ((i == 0 || has_nb[0]) && (j == 0 || has_nb[1]) && (k == 0 || has_nb[2])) begin
            res.cell_num = CellNumW'((i ? nb[0] : home[0]) + (j ? nb[1] : home[1]) * n
                                     + (k ? nb[2] : home[2]) * n * n);
            res.last = 0;
            cell_queue.insert(cell_queue.size(), res);
          end
        end
      end
    end
    cell_queue[cell_queue.size() - 1].last = 1;
  endfunction

  // Register writes track the block's configuration.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_ext <= 31'd6553600;
      cell_len  <= 31'd409600;
      halo_len  <= 31'd163840;
      grid_n    <= 5'd16;
      spd_max   <= 31'd131072;
      spd_min   <= 31'd32768;
    end else if (cfg_valid_i && cfg_ready_i) begin
      case (cfg_index_i)
        CFG_FIELD_EXTENT:   field_ext <= cfg_data_i[30:0];
        CFG_CELL_EDGE:      cell_len  <= cfg_data_i[30:0];
        CFG_HALO_BAND:      halo_len  <= cfg_data_i[30:0];
        CFG_CELLS_PER_AXIS: grid_n    <= cfg_data_i[4:0];
        CFG_SPEED_CEILING:  spd_max   <= cfg_data_i[30:0];
        CFG_SPEED_FLOOR:    spd_min   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Prediction on each accepted item, comparison on each result strobe.
  initial errors_o = 0;
  always @(posedge clk_i) begin
    cell_result_t got, want;
    if (rst_ni && start && !busy)
      predict_cells({pos_z_i, pos_y_i, pos_x_i}, {vel_z_i, vel_y_i, vel_x_i},
                    {delta_z_i, delta_y_i, delta_x_i});
    if (rst_ni && out_strobe_i) begin
      got.pos = {new_pos_z_i, new_pos_y_i, new_pos_x_i};
      got.vel = {new_vel_z_i, new_vel_y_i, new_vel_x_i};
      got.cell_num = cell_number_i;
      got.last = final_cell_i;
      if (cell_queue.size() == 0) begin
        errors_o <= errors_o + 1;
        $display("%0t: unexpected result, cell %0d", $realtime, cell_number_i);
      end else begin
        want = cell_queue.pop_front();
        if (got !== want) begin
          errors_o <= errors_o + 1;
          $display("%0t: mismatch: expected pos %h %h %h vel %h %h %h cell %0d last %b",
                   $realtime, want.pos[0], want.pos[1], want.pos[2], want.vel[0],
                   want.vel[1], want.vel[2], want.cell_num, want.last);
          $display("%0t:           actual pos %h %h %h vel %h %h %h cell %0d last %b",
                   $realtime, got.pos[0], got.pos[1], got.pos[2], got.vel[0],
                   got.vel[1], got.vel[2], got.cell_num, got.last);
        end
      end
    end
  end

endmodule

// ===== test/agent_integrate_and_grid_bin_tb.sv =====
// Testbench top for the agent integrate-and-bin block: clock, reset, register writes
// and agent stimulus in bursts. Depends on agb_pkg, the block and agb_result_checker.
`timescale 1ns / 100ps

module agent_integrate_and_grid_bin_tb;
  import agb_pkg::*;

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                start = 0;
  logic                busy;
  logic [30:0]         pos_x_i = 0, pos_y_i = 0, pos_z_i = 0;
  logic signed [31:0]  vel_x_i = 0, vel_y_i = 0, vel_z_i = 0;
  logic signed [31:0]  delta_x_i = 0, delta_y_i = 0, delta_z_i = 0;
  logic                cfg_valid_i = 0;
  logic                cfg_ready_o;
  logic [2:0]          cfg_index_i = 0;
  logic [31:0]         cfg_data_i = 0;
  logic                out_strobe_o;
  logic [30:0]         new_pos_x_o, new_pos_y_o, new_pos_z_o;
  logic signed [31:0]  new_vel_x_o, new_vel_y_o, new_vel_z_o;
  logic [CellNumW-1:0] cell_number_o;
  logic                final_cell_o;
  int                  errors, pending;
  int                  burst_left;
  bit                  gaps_on;
  logic [30:0]         fe_now, edge_now;

  agent_integrate_and_grid_bin dut (.*);

  agb_result_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .pos_x_i, .pos_y_i, .pos_z_i,
    .vel_x_i, .vel_y_i, .vel_z_i, .delta_x_i, .delta_y_i, .delta_z_i,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .out_strobe_i(out_strobe_o), .new_pos_x_i(new_pos_x_o), .new_pos_y_i(new_pos_y_o),
    .new_pos_z_i(new_pos_z_o), .new_vel_x_i(new_vel_x_o), .new_vel_y_i(new_vel_y_o),
    .new_vel_z_i(new_vel_z_o), .cell_number_i(cell_number_o),
    .final_cell_i(final_cell_o), .errors_o(errors), .pending_o(pending)
  );

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("agent_integrate_and_grid_bin_tb: done, errors");
    $finish;
  end

  // Presents one item and holds it until the block takes it.
  task automatic send_agent(input logic [30:0] px, py, pz,
                            input logic [31:0] vx, vy, vz, dx, dy, dz);
    pos_x_i <= px; pos_y_i <= py; pos_z_i <= pz;
    vel_x_i <= vx; vel_y_i <= vy; vel_z_i <= vz;
    delta_x_i <= dx; delta_y_i <= dy; delta_z_i <= dz;
    start <= 1;
    do @(posedge clk_i); while (busy);
  endtask

  // Sender bursts: start drops only between bursts.
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        start <= 0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  endtask

  task automatic write_reg(input agb_cfg_idx_e idx, input logic [31:0] data);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  // Lets every outstanding result drain, then the pipeline settle.
  task automatic drain();
    start <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_vel();
    return $urandom_range(0, 3) == 0 ? $urandom() : 32'($signed($urandom_range(0, 524288)) - 262144);
  endfunction

  // Mostly in-field agents at modest speed, with full-range noise mixed in.
  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7)
        send_agent($urandom_range(0, fe_now), $urandom_range(0, fe_now),
                   $urandom_range(0, fe_now), rand_vel(), rand_vel(), rand_vel(),
                   rand_vel(), rand_vel(), rand_vel());
      else
        send_agent($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom(), $urandom());
      pace_sender();
    end
  endtask

  task automatic random_config();
    logic [30:0] h, sm;
    fe_now = $urandom_range(65536, 1 << 28);
    edge_now = $urandom_range(65536, fe_now / 3 + 65536);
    h = $urandom_range(0, edge_now);
    sm = $urandom_range(0, 1 << 20);
    write_reg(CFG_FIELD_EXTENT, fe_now);
    write_reg(CFG_CELL_EDGE, edge_now);
    write_reg(CFG_HALO_BAND, h);
    write_reg(CFG_CELLS_PER_AXIS, $urandom_range(3, 16));
    write_reg(CFG_SPEED_CEILING, sm + $urandom_range(0, 1 << 20));
    write_reg(CFG_SPEED_FLOOR, sm);
  endtask

  initial begin
    burst_left = 0;
    gaps_on = 1;
    fe_now = 31'd6553600;
    edge_now = 31'd409600;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed agents under the reset configuration.
    send_agent(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_agent('1, '1, '1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_agent(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000,
               32'h80000000, 32'h80000000, 32'h80000000);
    // Slow agent raised to the floor, fast agent cut to the ceiling.
    send_agent(3000000, 3000000, 3000000, 1, 0, 0, 0, 0, 0);
    send_agent(3000000, 3000000, 3000000, 32'h00100000, -32'sd1048576, 5, 0, 0, 0);
    // Wrap below zero and above the field edge.
    send_agent(0, 100, 0, -32'sd65536, 0, 0, 0, -32'sd1000, 0);
    send_agent(6553600 - 16384, 6553600, 6553600, 65536, 0, 0, 0, 0, 0);
    // Position equal to the field edge lands in the top cell.
    send_agent(6553600, 6553600, 6553600, 0, 0, 0, 0, 0, 0);
    // One wrap is not enough: the position is clamped.
    send_agent('1, '1, 0, 65536, 0, 0, 0, 0, 0);
    // Low band, high band and mid cell on different axes.
    send_agent(409600 * 3 + 1, 409600 * 4 - 1, 409600 * 3 + 204800, 0, 0, 0, 0, 0, 0);
    send_agent(409600 * 3 + 204800, 409600 * 5 + 204800, 409600 * 7 + 204800,
               0, 0, 0, 0, 0, 0);
    send_agent(1, 1, 409600 * 16 - 1, 0, 0, 0, 0, 0, 0);
    send_agent(409600 * 15 + 1, 409600 * 15 + 409599, 0, 0, 0, 0,
               32'h7FFFFFFF, 32'h80000000, 32'h00000001);
    send_agent(12345, 0, 0, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
    send_random(15);
    drain();

    // Extremes: widest field, zero edge and band, grid clamped up, no floor.
    fe_now = 31'h7FFFFFFF;
    write_reg(CFG_FIELD_EXTENT, 32'hFFFFFFFF);
    write_reg(CFG_CELL_EDGE, 0);
    write_reg(CFG_HALO_BAND, 0);
    write_reg(CFG_CELLS_PER_AXIS, 0);
    write_reg(CFG_SPEED_CEILING, 32'h7FFFFFFF);
    write_reg(CFG_SPEED_FLOOR, 0);
    send_random(25);
    drain();

    // Extremes: smallest field, band past the edge, grid clamped down, zero ceiling.
    fe_now = 31'd65536;
    write_reg(CFG_FIELD_EXTENT, 65536);
    write_reg(CFG_CELL_EDGE, 65536);
    write_reg(CFG_HALO_BAND, 32'h7FFFFFFF);
    write_reg(CFG_CELLS_PER_AXIS, 31);
    write_reg(CFG_SPEED_CEILING, 0);
    write_reg(CFG_SPEED_FLOOR, 32'h7FFFFFFF);
    send_random(20);
    drain();

    // Random settings; the last phase runs without sender gaps.
    for (int ph = 0; ph < 4; ph++) begin
      random_config();
      gaps_on = (ph != 3);
      send_random(25);
      drain();
    end

    if (errors == 0 && pending == 0)
      $display("agent_integrate_and_grid_bin_tb: done, clean");
    else
      $display("agent_integrate_and_grid_bin_tb: done, errors");
    $finish;
  end

endmodule

// ===== agent_integrate_and_grid_bin.f =====
hw/rtl/agb_pkg.sv
hw/rtl/agb_vel_unit.sv
hw/rtl/agb_sqrt_pipe.sv
hw/rtl/agb_scale_pipe.sv
hw/rtl/agb_bin_pipe.sv
hw/rtl/agb_cell_emit.sv
hw/rtl/agent_integrate_and_grid_bin.sv
test/agb_result_checker.sv
test/agent_integrate_and_grid_bin_tb.sv
